FILE: hw/rtl/gne_pkg.sv
// Shared types and constants of the gate netlist evaluator.
package gne_pkg;

    // Default netlist size
    localparam int MAX_GATES_DEF  = 16;
    localparam int MAX_INPUTS_DEF = 8;

    // Fixed field widths
    localparam int SLOT_W  = 4;
    localparam int SRC_W   = 5;
    localparam int BITS_W  = 8;
    localparam int GCNT_W  = 5;
    localparam int ICNT_W  = 4;
    localparam int FAIL_W  = 4;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // Operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    // Register select, taken from address bit 2
    localparam logic REG_GATES_IN_USE  = 1'b0;
    localparam logic REG_INPUTS_IN_USE = 1'b1;

    typedef enum logic [1:0] {
        KIND_AND    = 2'd0,
        KIND_OR     = 2'd1,
        KIND_NOT    = 2'd2,
        KIND_TOGGLE = 2'd3
    } t_gate_kind;

    typedef struct packed {
        logic              operation;
        logic [SLOT_W-1:0] gate_slot;
        logic [1:0]        gate_kind;
        logic [SRC_W-1:0]  source_first;
        logic [SRC_W-1:0]  source_second;
        logic [BITS_W-1:0] input_bits;
    } t_in_item;

    typedef struct packed {
        logic              result_bit;
        logic              error_flag;
        logic [FAIL_W-1:0] failing_gate;
    } t_out_item;

    // Stored gate entry, kind in the low bits
    typedef struct packed {
        logic [SRC_W-1:0] second;
        logic [SRC_W-1:0] first;
        t_gate_kind       kind;
    } t_gate_entry;

    typedef struct packed {
        logic [GCNT_W-1:0] gates_in_use;
        logic [ICNT_W-1:0] inputs_in_use;
    } t_cfg;

endpackage

FILE: hw/rtl/gne_walk.sv
// Gate table, value memory and the pipelined walk over the netlist.
module gne_walk #(
    parameter int MAX_GATES  = gne_pkg::MAX_GATES_DEF,
    parameter int MAX_INPUTS = gne_pkg::MAX_INPUTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  gne_pkg::t_in_item i_item,
    input  gne_pkg::t_cfg     i_cfg,
    output logic              o_busy,
    output logic              o_done,
    output gne_pkg::t_out_item o_result
);
    import gne_pkg::*;

    localparam int GIW = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
    localparam int NIW = $clog2(MAX_INPUTS + 1);

    // Storage
    t_gate_entry          r_table [0:MAX_GATES-1];
    logic                 r_vmem  [0:MAX_GATES-1];
    logic [MAX_GATES-1:0] r_valid;
    logic [MAX_GATES-1:0] r_toggle;

    // Pass control
    logic              r_busy;
    logic              r_issue_on;
    logic [GIW-1:0]    r_idx;
    logic [GIW-1:0]    r_last;
    logic [NIW-1:0]    r_nin;
    logic [BITS_W-1:0] r_bits;

    // Stage B: table entry read back
    logic              r_b_vld;
    logic [GIW-1:0]    r_b_idx;
    t_gate_entry       r_tab_q;

    // Stage C: operands read back, evaluate
    logic              r_c_vld;
    logic [GIW-1:0]    r_c_idx;
    t_gate_entry       r_c_entry;
    logic              r_va_q;
    logic              r_vb_q;

    // Forward of the gate written in the previous cycle
    logic              r_fw_en;
    logic [GIW-1:0]    r_fw_idx;
    logic              r_fw_val;

    logic              r_out_vld;
    t_out_item         r_out;

    logic              is_load;
    logic              is_eval;
    logic              slot_ok;
    logic [GIW-1:0]    slot_idx;
    logic [GIW-1:0]    rd_a;
    logic [GIW-1:0]    rd_b;
    logic [GIW-1:0]    n_last;
    logic [NIW-1:0]    n_nin;
    logic              ok_a;
    logic              ok_b;
    logic              val_a;
    logic              val_b;
    logic              ok_all;
    logic              gate_out;
    logic              c_write;
    logic              c_stop;

    // Decode the operand of a source index: availability and value
    function automatic logic [1:0] fetch_src(
        input logic [SRC_W-1:0]  src,
        input logic              mem_val,
        input logic [NIW-1:0]    nin,
        input logic [BITS_W-1:0] bits,
        input logic [GIW-1:0]    last,
        input logic [MAX_GATES-1:0] valid,
        input logic              fw_en,
        input logic [GIW-1:0]    fw_idx,
        input logic              fw_val,
        input logic [GIW-1:0]    cur_idx
    );
        logic [31:0]    s32;
        logic [31:0]    g32;
        logic [GIW-1:0] gi;
        logic           ok;
        logic           v;
        s32 = 32'(src);
        g32 = s32 - 32'(MAX_INPUTS);
        gi  = GIW'(g32);
        ok  = 1'b0;
        v   = 1'b0;
        if (s32 < 32'(MAX_INPUTS)) begin
            ok = (s32 < 32'(nin));
            v  = (s32 < 32'(BITS_W)) ? bits[src[2:0]] : 1'b0;
        end else if (g32 < 32'(MAX_GATES) && g32 <= 32'(last)) begin
            ok = valid[gi];
            v  = (fw_en && gi == fw_idx && gi != cur_idx) ? fw_val : mem_val;
        end
        return {ok, v};
    endfunction

    assign is_load  = i_accept && (i_item.operation == OP_LOAD);
    assign is_eval  = i_accept && (i_item.operation == OP_EVAL);
    assign slot_ok  = (32'(i_item.gate_slot) < 32'(MAX_GATES));
    assign slot_idx = GIW'(i_item.gate_slot);

    // Clamp the gate and input counts for the pass
    always_comb begin
        logic [31:0] ng;
        logic [31:0] ni;
        ng = 32'(i_cfg.gates_in_use);
        if (ng == 32'd0) ng = 32'd1;
        if (ng > 32'(MAX_GATES)) ng = 32'(MAX_GATES);
        ni = 32'(i_cfg.inputs_in_use);
        if (ni > 32'(MAX_INPUTS)) ni = 32'(MAX_INPUTS);
        n_last = GIW'(ng - 32'd1);
        n_nin  = NIW'(ni);
    end

    // Gate memory addresses for the operand reads
    assign rd_a = GIW'(32'(r_tab_q.first)  - 32'(MAX_INPUTS));
    assign rd_b = GIW'(32'(r_tab_q.second) - 32'(MAX_INPUTS));

    // Evaluate the gate in stage C
    always_comb begin
        logic [1:0] fa;
        logic [1:0] fb;
        fa = fetch_src(r_c_entry.first, r_va_q, r_nin, r_bits, r_last, r_valid,
                       r_fw_en, r_fw_idx, r_fw_val, r_c_idx);
        fb = fetch_src(r_c_entry.second, r_vb_q, r_nin, r_bits, r_last, r_valid,
                       r_fw_en, r_fw_idx, r_fw_val, r_c_idx);
        ok_a  = fa[1];
        val_a = fa[0];
        ok_b  = fb[1];
        val_b = fb[0];
        case (r_c_entry.kind)
            KIND_AND: begin
                ok_all   = ok_a && ok_b;
                gate_out = val_a & val_b;
            end
            KIND_OR: begin
                ok_all   = ok_a && ok_b;
                gate_out = val_a | val_b;
            end
            KIND_NOT: begin
                ok_all   = ok_a;
                gate_out = ~val_a;
            end
            KIND_TOGGLE: begin
                ok_all   = ok_a;
                gate_out = val_a ^ r_toggle[r_c_idx];
            end
            default: begin
                ok_all   = 1'b0;
                gate_out = 1'b0;
            end
        endcase
        c_write = r_c_vld && ok_all;
        c_stop  = r_c_vld && (!ok_all || r_c_idx == r_last);
    end

    // Gate table: written by load items, read one entry a cycle in the walk
    always_ff @(posedge i_clk) begin
        if (is_load && slot_ok) begin
            r_table[slot_idx] <= t_gate_entry'({i_item.source_second,
                                                i_item.source_first,
                                                i_item.gate_kind});
        end
        r_tab_q <= r_table[r_idx];
    end

    // Gate output memory: one write, two operand reads
    always_ff @(posedge i_clk) begin
        if (c_write) begin
            r_vmem[r_c_idx] <= gate_out;
        end
        r_va_q <= r_vmem[rd_a];
        r_vb_q <= r_vmem[rd_b];
    end

    // Stage payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_b_idx   <= r_idx;
        r_c_idx   <= r_b_idx;
        r_c_entry <= r_tab_q;
        r_fw_idx  <= r_c_idx;
        r_fw_val  <= gate_out;
        if (is_eval) begin
            r_last <= n_last;
            r_nin  <= n_nin;
            r_bits <= i_item.input_bits;
        end
        if (c_stop) begin
            r_out.result_bit   <= ok_all ? gate_out : 1'b0;
            r_out.error_flag   <= ~ok_all;
            r_out.failing_gate <= ok_all ? '0 : FAIL_W'(r_c_idx);
        end
    end

    // Control: issue, advance, flush on the end of the pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_issue_on <= 1'b0;
            r_idx      <= '0;
            r_b_vld    <= 1'b0;
            r_c_vld    <= 1'b0;
            r_fw_en    <= 1'b0;
            r_out_vld  <= 1'b0;
            r_valid    <= '0;
            r_toggle   <= '0;
        end else begin
            r_out_vld <= c_stop;
            r_fw_en   <= c_write;
            if (c_stop) begin
                r_busy     <= 1'b0;
                r_issue_on <= 1'b0;
                r_b_vld    <= 1'b0;
                r_c_vld    <= 1'b0;
            end else begin
                r_b_vld <= r_issue_on;
                r_c_vld <= r_b_vld;
                if (r_issue_on) begin
                    r_idx <= r_idx + GIW'(1);
                    if (r_idx == r_last) r_issue_on <= 1'b0;
                end
            end
            if (is_eval) begin
                r_busy     <= 1'b1;
                r_issue_on <= 1'b1;
                r_idx      <= '0;
            end
            // Mark computed on write, drop the mark on load
            if (c_write) begin
                r_valid[r_c_idx] <= 1'b1;
                if (r_c_entry.kind == KIND_TOGGLE) r_toggle[r_c_idx] <= gate_out;
            end
            if (is_load && slot_ok) begin
                r_valid[slot_idx] <= 1'b0;
            end
        end
    end

    assign o_busy   = r_busy;
    assign o_done   = r_out_vld;
    assign o_result = r_out;

endmodule

FILE: hw/rtl/gate_netlist_evaluator.sv
// Top level of the gate netlist evaluator: item port, register port, walk.
//
// Usage. An item is taken at a rising edge with start high and busy low.
// A load item (operation 0) writes one gate entry and clears that gate's
// computed mark; it gives no result and leaves busy low.
// An evaluate item (operation 1) brings the primary input bits and walks
// gates 0 .. gates_in_use-1, with gates_in_use held to 1 .. MAX_GATES,
// through a three-stage loop: table read, operand read from the gate output
// memory, evaluate and write back, with the previous gate's output forwarded
// around the memory, one gate a cycle. Busy is high from the taken item until
// the result strobe o_result_valid, so no item is taken while a pass runs; a
// gate whose operand is not available stops the pass early with an error.
// The result is shown for exactly one cycle and the receiver cannot hold
// it off. Registers: byte address 0 gates_in_use, 4 primary_inputs_in_use,
// written through the APB port. The user must write them only while the
// block is idle; the block itself does not enforce this.
// Reset clears the computed marks, the toggle bits and the registers
// (gates_in_use to 1, primary_inputs_in_use to 0); gate entries stay
// undefined until loaded.
module gate_netlist_evaluator #(
    parameter int MAX_GATES  = gne_pkg::MAX_GATES_DEF,
    parameter int MAX_INPUTS = gne_pkg::MAX_INPUTS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  gne_pkg::t_in_item          i_item,
    output logic                       o_result_valid,
    output gne_pkg::t_out_item         o_result,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gne_pkg::APB_AW-1:0] paddr,
    input  logic [gne_pkg::APB_DW-1:0] pwdata,
    output logic [gne_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import gne_pkg::*;

    t_cfg  r_cfg;
    logic  apb_wr;
    logic  accept;
    logic  walk_busy;

    assign apb_wr = psel && penable && pwrite;
    assign accept = start && !walk_busy;
    assign pready = 1'b1;
    assign busy   = walk_busy;

    // Hold the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gates_in_use  <= GCNT_W'(1);
            r_cfg.inputs_in_use <= '0;
        end else begin
            if (apb_wr) begin
                case (paddr[2])
                    REG_GATES_IN_USE:  r_cfg.gates_in_use  <= pwdata[GCNT_W-1:0];
                    REG_INPUTS_IN_USE: r_cfg.inputs_in_use <= pwdata[ICNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Return the register read back
    always_comb begin
        prdata = '0;
        case (paddr[2])
            REG_GATES_IN_USE:  prdata = APB_DW'(r_cfg.gates_in_use);
            REG_INPUTS_IN_USE: prdata = APB_DW'(r_cfg.inputs_in_use);
            default:           prdata = '0;
        endcase
    end

    gne_walk #(
        .MAX_GATES  (MAX_GATES),
        .MAX_INPUTS (MAX_INPUTS)
    ) u_walk (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .i_cfg    (r_cfg),
        .o_busy   (walk_busy),
        .o_done   (o_result_valid),
        .o_result (o_result)
    );

endmodule
